[src/irb_pkg.sv]
`timescale 1ns / 1ps
// irb_pkg: types, codes and pointer helpers of the indexed ring buffer
// no dependencies; imported by indexed_ring_buffer_top, irb_result_checker and the testbench

package irb_pkg;

   localparam int DEPTH     = 16;
   localparam int ITEM_BITS = 32;
   localparam int PTR_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   // request codes
   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_PEEK   = 3'd2,
      OP_GET    = 3'd3,
      OP_REMOVE = 3'd4,
      OP_CLEAR  = 3'd5
   } irb_op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } irb_status_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_CAPACITY  = 2'd0,
      CSR_OVERWRITE = 2'd1,
      CSR_ORDER     = 2'd2
   } irb_csr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_RD,
      S_MV_WR,
      S_SH_RD,
      S_SH_WR
   } irb_state_type;

   typedef struct packed {
      logic [2:0]           req_type;
      logic [ITEM_BITS-1:0] item_data;
      logic [PTR_BITS-1:0]  position;
   } irb_req_word_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [ITEM_BITS-1:0] item_out;
      logic [CNT_BITS-1:0]  fill_count;
   } irb_rsp_word_type;

   // next slot, wrapping at the capacity
   function automatic logic [PTR_BITS-1:0] wrap_inc(input logic [PTR_BITS-1:0] x,
                                                    input logic [CNT_BITS-1:0] cap);
      logic [CNT_BITS-1:0] nx;
      nx = CNT_BITS'(x) + CNT_BITS'(1);
      return (nx == cap) ? '0 : nx[PTR_BITS-1:0];
   endfunction

   // previous slot, wrapping at the capacity
   function automatic logic [PTR_BITS-1:0] wrap_dec(input logic [PTR_BITS-1:0] x,
                                                    input logic [CNT_BITS-1:0] cap);
      logic [CNT_BITS-1:0] pv;
      pv = cap - CNT_BITS'(1);
      return (x == '0) ? pv[PTR_BITS-1:0] : x - PTR_BITS'(1);
   endfunction

endpackage

[src/indexed_ring_buffer_top.sv]
`timescale 1ns / 1ps
// indexed_ring_buffer_top: circular buffer with push, pop, peek, get, remove, clear
// depends on irb_pkg
//
// usage
//   req channel takes one request word (op, item, logical position), rsp
//   channel returns exactly one result word (status, item, fill count) per
//   request, in order. csr channel writes capacity, overwrite mode and
//   remove-order mode; it is meant to be written while the block is idle.
//   writing the capacity empties the buffer (stored data is kept).
// result timing
//   push, clear, unused codes and any failing request: result valid in the
//   cycle after accept.
//   pop, peek, get and unordered remove with words behind the gap: one
//   storage read into the read register, then the result register.
//   ordered remove: S_SH_RD then S_SH_WR for each of the k words behind
//   the removed one, a read-then-write loop through the slot memory; a remove
//   of the newest word in either mode is answered in the cycle after accept.
//   a new request is taken when the sequencer is idle and the result
//   register is free or being drained in that cycle.
// reset: synchronous, empties the buffer and loads capacity 16, no
//   overwrite, ordered remove. slot contents are not cleared.
// stall: a waiting result holds in the result register; no new request is
//   taken until it drains.

module indexed_ring_buffer_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  irb_pkg::irb_req_word_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output irb_pkg::irb_rsp_word_type rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [4:0]                csr_wdata
);
   import irb_pkg::*;

   // slot memory, one write and one registered read per cycle
   logic [ITEM_BITS-1:0] mem_q [DEPTH];
   logic [ITEM_BITS-1:0] rd_data_ff;
   logic                 mem_we;
   logic [PTR_BITS-1:0]  mem_waddr;
   logic [PTR_BITS-1:0]  mem_raddr;
   logic [ITEM_BITS-1:0] mem_wdata;

   irb_state_type        state_ff, state_in;
   logic [PTR_BITS-1:0]  wp_ff, wp_in;
   logic [PTR_BITS-1:0]  rp_ff, rp_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [4:0]           cap_ff, cap_in;
   logic                 ovw_ff, ovw_in;
   logic                 ord_ff, ord_in;
   logic [PTR_BITS-1:0]  cur_ff, cur_in;
   logic [PTR_BITS-1:0]  nxt_ff, nxt_in;
   logic [PTR_BITS-1:0]  left_ff, left_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   irb_rsp_word_type     rsp_ff, rsp_in;

   logic [CNT_BITS-1:0]  cap_eff;
   logic                 req_fire;
   logic                 csr_fire;
   logic                 is_full;
   logic                 is_empty;
   logic                 pos_bad;
   logic [CNT_BITS-1:0]  moves_w;
   logic [PTR_BITS-1:0]  moves;

   // shared wrap adder: (base + off) mod capacity, both operands below it
   logic [PTR_BITS-1:0]  wu_base;
   logic [PTR_BITS-1:0]  wu_off;
   logic [CNT_BITS-1:0]  wu_sum;
   logic [PTR_BITS-1:0]  wu_res;

   // capacity of zero acts as one, above the depth acts as the depth
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CNT_BITS'(1);
      end else if (cap_ff > 5'(DEPTH)) begin
         cap_eff = CNT_BITS'(DEPTH);
      end else begin
         cap_eff = CNT_BITS'(cap_ff);
      end
   end

   always_comb begin
      wu_sum = CNT_BITS'(wu_base) + CNT_BITS'(wu_off);
      if (wu_sum >= cap_eff) begin
         wu_sum = wu_sum - cap_eff;
      end
      wu_res = wu_sum[PTR_BITS-1:0];
   end

   // operand select for the wrap adder
   always_comb begin
      if (state_ff == S_SH_RD) begin
         wu_base = cur_ff;
         wu_off  = PTR_BITS'(1);
      end else begin
         wu_base = rp_ff;
         wu_off  = req_data.position;
      end
   end

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign is_full  = (cnt_ff >= cap_eff);
   assign is_empty = (cnt_ff == '0);
   assign pos_bad  = (CNT_BITS'(req_data.position) >= cnt_ff);
   // items behind the removed one
   assign moves_w  = cnt_ff - CNT_BITS'(1) - CNT_BITS'(req_data.position);
   assign moves    = moves_w[PTR_BITS-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_data.req_type)
                  OP_POP, OP_PEEK: begin
                     state_in = is_empty ? S_IDLE : S_RD;
                  end
                  OP_GET: begin
                     state_in = pos_bad ? S_IDLE : S_RD;
                  end
                  OP_REMOVE: begin
                     if (pos_bad || moves == '0) begin
                        state_in = S_IDLE;
                     end else begin
                        state_in = ord_ff ? S_SH_RD : S_MV_WR;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_RD:    state_in = S_IDLE;
         S_MV_WR: state_in = S_IDLE;
         S_SH_RD: state_in = S_SH_WR;
         S_SH_WR: begin
            state_in = (left_ff == PTR_BITS'(1)) ? S_IDLE : S_SH_RD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      cnt_in       = cnt_ff;
      cap_in       = cap_ff;
      ovw_in       = ovw_ff;
      ord_in       = ord_ff;
      cur_in       = cur_ff;
      nxt_in       = nxt_ff;
      left_in      = left_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      mem_we       = 1'b0;
      mem_waddr    = cur_ff;
      mem_wdata    = rd_data_ff;
      mem_raddr    = rp_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_in.status     = ST_OK;
               rsp_in.item_out   = '0;
               rsp_in.fill_count = cnt_ff;
               rsp_valid_in      = 1'b1;
               case (req_data.req_type)
                  OP_PUSH: begin
                     if (is_full && !ovw_ff) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = wp_ff;
                        mem_wdata = req_data.item_data;
                        wp_in     = wrap_inc(wp_ff, cap_eff);
                        if (is_full) begin
                           // oldest word is dropped
                           rp_in = wrap_inc(rp_ff, cap_eff);
                        end else begin
                           cnt_in            = cnt_ff + CNT_BITS'(1);
                           rsp_in.fill_count = cnt_ff + CNT_BITS'(1);
                        end
                     end
                  end
                  OP_POP: begin
                     if (is_empty) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        mem_raddr         = rp_ff;
                        rp_in             = wrap_inc(rp_ff, cap_eff);
                        cnt_in            = cnt_ff - CNT_BITS'(1);
                        rsp_in.fill_count = cnt_ff - CNT_BITS'(1);
                        rsp_valid_in      = 1'b0;
                     end
                  end
                  OP_PEEK: begin
                     if (is_empty) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        mem_raddr    = rp_ff;
                        rsp_valid_in = 1'b0;
                     end
                  end
                  OP_GET: begin
                     if (pos_bad) begin
                        rsp_in.status = ST_RANGE;
                     end else begin
                        mem_raddr    = wu_res;
                        rsp_valid_in = 1'b0;
                     end
                  end
                  OP_REMOVE: begin
                     if (pos_bad) begin
                        rsp_in.status = ST_RANGE;
                     end else begin
                        wp_in             = wrap_dec(wp_ff, cap_eff);
                        cnt_in            = cnt_ff - CNT_BITS'(1);
                        rsp_in.fill_count = cnt_ff - CNT_BITS'(1);
                        cur_in            = wu_res;
                        left_in           = moves;
                        // newest word sits just before the write pointer
                        mem_raddr         = wrap_dec(wp_ff, cap_eff);
                        if (moves != '0) begin
                           rsp_valid_in = 1'b0;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     wp_in             = '0;
                     rp_in             = '0;
                     cnt_in            = '0;
                     rsp_in.fill_count = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_RD: begin
            rsp_in.item_out = rd_data_ff;
            rsp_valid_in    = 1'b1;
         end
         S_MV_WR: begin
            // newest word fills the gap
            mem_we       = 1'b1;
            mem_waddr    = cur_ff;
            mem_wdata    = rd_data_ff;
            rsp_valid_in = 1'b1;
         end
         S_SH_RD: begin
            mem_raddr = wu_res;
            nxt_in    = wu_res;
         end
         S_SH_WR: begin
            // move the later word down by one slot
            mem_we    = 1'b1;
            mem_waddr = cur_ff;
            mem_wdata = rd_data_ff;
            cur_in    = nxt_ff;
            left_in   = left_ff - PTR_BITS'(1);
            if (left_ff == PTR_BITS'(1)) begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (csr_fire) begin
         case (csr_index)
            CSR_CAPACITY: begin
               cap_in = csr_wdata;
               wp_in  = '0;
               rp_in  = '0;
               cnt_in = '0;
            end
            CSR_OVERWRITE: ovw_in = csr_wdata[0];
            CSR_ORDER:     ord_in = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // slot memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_q[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem_q[mem_raddr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         cnt_ff       <= '0;
         cap_ff       <= 5'(DEPTH);
         ovw_ff       <= 1'b0;
         ord_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         cnt_ff       <= cnt_in;
         cap_ff       <= cap_in;
         ovw_ff       <= ovw_in;
         ord_ff       <= ord_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // sequencer payload and result word
   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      nxt_ff  <= nxt_in;
      left_ff <= left_in;
      rsp_ff  <= rsp_in;
   end

endmodule

[test/irb_result_checker.sv]
`timescale 1ns / 1ps
// irb_result_checker: mirrors the ring buffer, predicts each result word and compares it
// depends on irb_pkg; instantiated beside the block by tb_indexed_ring_buffer_top

module irb_result_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  irb_pkg::irb_req_word_type req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  irb_pkg::irb_rsp_word_type rsp_data,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [4:0]                csr_wdata,
   output int                        fail_count,
   output int                        due_count,
   output int                        checked_count
);

   import irb_pkg::*;

   // mirrored buffer state
   logic [ITEM_BITS-1:0] ring_slots [DEPTH];
   logic [PTR_BITS-1:0]  head_slot;
   logic [PTR_BITS-1:0]  tail_slot;
   int unsigned          item_total;
   logic [4:0]           capacity_reg;
   logic                 overwrite_on;
   logic                 keep_order;

   irb_rsp_word_type     due_results [$];
   irb_rsp_word_type     oldest_due;

   initial begin
      fail_count    = 0;
      due_count     = 0;
      checked_count = 0;
   end

   // capacity as the buffer uses it
   function automatic int unsigned active_slots();
      if (capacity_reg == 5'd0) return 1;
      if (capacity_reg > DEPTH) return DEPTH;
      return capacity_reg;
   endfunction

   function automatic logic [PTR_BITS-1:0] slot_at(input int unsigned base,
                                                   input int unsigned off);
      return PTR_BITS'((base + off) % active_slots());
   endfunction

   function automatic void empty_ring();
      head_slot  = '0;
      tail_slot  = '0;
      item_total = 0;
   endfunction

   // applies one request to the mirror and returns the word it must produce
   function automatic irb_rsp_word_type ring_request_result(input irb_req_word_type w);
      int unsigned      cap;
      int unsigned      pos;
      int unsigned      i;
      irb_rsp_word_type r;
      cap        = active_slots();
      pos        = w.position;
      r.status   = ST_OK;
      r.item_out = '0;
      case (w.req_type)
         OP_PUSH: begin
            if (item_total >= cap && !overwrite_on) begin
               r.status = ST_FULL;
            end else begin
               // full with overwrite: oldest item drops out
               if (item_total >= cap) head_slot = slot_at(head_slot, 1);
               else item_total++;
               ring_slots[tail_slot] = w.item_data;
               tail_slot = slot_at(tail_slot, 1);
            end
         end
         OP_POP: begin
            if (item_total == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.item_out = ring_slots[head_slot];
               head_slot  = slot_at(head_slot, 1);
               item_total--;
            end
         end
         OP_PEEK: begin
            if (item_total == 0) r.status = ST_EMPTY;
            else r.item_out = ring_slots[head_slot];
         end
         OP_GET: begin
            if (pos >= item_total) r.status = ST_RANGE;
            else r.item_out = ring_slots[slot_at(head_slot, pos)];
         end
         OP_REMOVE: begin
            if (pos >= item_total) begin
               r.status = ST_RANGE;
            end else begin
               if (keep_order) begin
                  for (i = pos; i + 1 < item_total; i++)
                     ring_slots[slot_at(head_slot, i)] = ring_slots[slot_at(head_slot, i + 1)];
               end else if (pos + 1 < item_total) begin
                  ring_slots[slot_at(head_slot, pos)] =
                     ring_slots[slot_at(head_slot, item_total - 1)];
               end
               tail_slot = slot_at(tail_slot, cap - 1);
               item_total--;
            end
         end
         OP_CLEAR: empty_ring();
         default: ;
      endcase
      r.fill_count = CNT_BITS'(item_total);
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         empty_ring();
         capacity_reg = 5'd16;
         overwrite_on = 1'b0;
         keep_order   = 1'b1;
         due_results.delete();
      end else begin
         // result side first: it belongs to an earlier request
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               $error("result word with no request waiting: status %0d item %h fill %0d",
                      rsp_data.status, rsp_data.item_out, rsp_data.fill_count);
               fail_count++;
            end else begin
               oldest_due = due_results.pop_front();
               checked_count++;
               if (rsp_data.status !== oldest_due.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         oldest_due.status, rsp_data.status);
                  fail_count++;
               end
               if (rsp_data.item_out !== oldest_due.item_out) begin
                  $error("item_out mismatch: expected %h, actual %h",
                         oldest_due.item_out, rsp_data.item_out);
                  fail_count++;
               end
               if (rsp_data.fill_count !== oldest_due.fill_count) begin
                  $error("fill_count mismatch: expected %0d, actual %0d",
                         oldest_due.fill_count, rsp_data.fill_count);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CAPACITY: begin
                  capacity_reg = csr_wdata;
                  empty_ring();
               end
               CSR_OVERWRITE: overwrite_on = csr_wdata[0];
               CSR_ORDER:     keep_order   = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            due_results.push_back(ring_request_result(req_data));
      end
      due_count = due_results.size();
   end

endmodule

[test/tb_indexed_ring_buffer_top.sv]
`timescale 1ns / 1ps
// tb_indexed_ring_buffer_top: stimulus and verdict for the indexed ring buffer
// depends on irb_pkg, indexed_ring_buffer_top and irb_result_checker

module tb_indexed_ring_buffer_top;

   import irb_pkg::*;

   // request codes the block has no use for, and the unused register slot
   localparam logic [2:0] OP_SPARE_SIX   = 3'd6;
   localparam logic [2:0] OP_SPARE_SEVEN = 3'd7;
   localparam logic [1:0] CSR_SPARE      = 2'd3;

   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 48;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   irb_req_word_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b1;
   irb_rsp_word_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index = CSR_CAPACITY;
   logic [4:0]       csr_wdata = '0;

   int fail_count;
   int due_count;
   int checked_count;

   // stimulus bookkeeping
   bit idling_on     = 1'b0;
   int capacity_now  = 16;
   int request_total = 0;
   int csr_total     = 0;
   int setting_total = 0;

   always #10 clock = ~clock;

   indexed_ring_buffer_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   irb_result_checker checker_0 (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .due_count     (due_count),
      .checked_count (checked_count)
   );

   // result side back-pressure: random stall bursts while idling is on
   initial begin
      forever begin
         @(posedge clock);
         if (idling_on && !reset && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   // one request word; valid stays up across back-to-back words
   task automatic send_request(input logic [2:0] op, input logic [31:0] data,
                               input logic [3:0] pos);
      irb_req_word_type w;
      w.req_type  = op;
      w.item_data = data;
      w.position  = pos;
      // sender gap
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      request_total++;
   endtask

   // stop sending and wait for every outstanding result word
   task automatic drain_requests();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (due_count == 0);
   endtask

   // one register word; caller lowers csr_valid after the last one
   task automatic write_csr(input logic [1:0] idx, input logic [4:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_total++;
   endtask

   // full setting: capacity (empties the buffer), overwrite mode, remove order
   task automatic apply_setting(input logic [4:0] cap, input bit ovw, input bit keep);
      drain_requests();
      write_csr(CSR_CAPACITY, cap);
      // upper data bits are don't-care for the mode registers
      write_csr(CSR_OVERWRITE, {4'($urandom_range(0, 15)), ovw});
      write_csr(CSR_ORDER, {4'($urandom_range(0, 15)), keep});
      csr_valid <= 1'b0;
      capacity_now = (cap == 0) ? 1 : ((cap > DEPTH) ? DEPTH : int'(cap));
      setting_total++;
   endtask

   // mode change alone, buffer contents stay
   task automatic set_overwrite(input bit ovw);
      drain_requests();
      write_csr(CSR_OVERWRITE, {4'd0, ovw});
      csr_valid <= 1'b0;
      setting_total++;
   endtask

   // random request, push share set per phase
   task automatic random_request(input int push_weight);
      int          pick;
      logic [2:0]  op;
      logic [31:0] data;
      logic [3:0]  pos;
      pick = $urandom_range(0, push_weight + 59);
      if (pick < push_weight)           op = OP_PUSH;
      else if (pick < push_weight + 12) op = OP_POP;
      else if (pick < push_weight + 20) op = OP_PEEK;
      else if (pick < push_weight + 38) op = OP_GET;
      else if (pick < push_weight + 54) op = OP_REMOVE;
      else if (pick < push_weight + 56) op = OP_CLEAR;
      else if (pick < push_weight + 58) op = OP_SPARE_SIX;
      else                              op = OP_SPARE_SEVEN;
      case ($urandom_range(0, 9))
         0:       data = 32'h0000_0000;
         1:       data = 32'hFFFF_FFFF;
         default: data = $urandom;
      endcase
      // mostly positions inside the capacity, some anywhere
      if ($urandom_range(0, 3) == 0) pos = 4'($urandom_range(0, 15));
      else pos = 4'($urandom_range(0, capacity_now - 1));
      send_request(op, data, pos);
   endtask

   initial begin
      logic [4:0] cap_plan [RANDOM_PHASES];
      int         push_weight;
      cap_plan = '{5'd16, 5'd3, 5'd1, 5'd8, 5'd0, 5'd31, 5'd2, 5'd17, 5'd5, 5'd16};
      cap_plan[RANDOM_PHASES - 2] = 5'($urandom_range(1, 16));

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: capacity 16, refuse when full, ordered remove
      idling_on = 1'b1;
      send_request(OP_POP, 32'h0, 4'h0);                 // empty pop
      send_request(OP_PEEK, 32'hFFFF_FFFF, 4'hF);        // empty peek
      send_request(OP_GET, 32'h0, 4'h0);                 // get on empty
      send_request(OP_REMOVE, 32'h0, 4'hF);              // remove on empty
      send_request(OP_PUSH, 32'h0000_0000, 4'h0);
      send_request(OP_PUSH, 32'hFFFF_FFFF, 4'hF);
      send_request(OP_PUSH, 32'h5A5A_C3C3, 4'h0);
      send_request(OP_GET, 32'h0, 4'hF);                 // past the count
      send_request(OP_GET, 32'h0, 4'h2);
      send_request(OP_REMOVE, 32'h0, 4'h0);              // shifts two items down
      send_request(OP_PEEK, 32'h0, 4'h0);
      send_request(OP_SPARE_SIX, $urandom, 4'hF);
      send_request(OP_SPARE_SEVEN, $urandom, 4'h5);
      send_request(OP_CLEAR, 32'h0, 4'h0);

      // tiny buffer, refuse when full, newest fills the gap on remove
      apply_setting(5'd2, 1'b0, 1'b0);
      @(posedge clock);
      write_csr(CSR_SPARE, 5'h1F);                       // unused index, no effect
      csr_valid <= 1'b0;
      send_request(OP_PUSH, 32'hA000_0001, 4'h0);
      send_request(OP_PUSH, 32'hA000_0002, 4'h0);
      send_request(OP_PUSH, 32'hA000_0003, 4'h0);        // refused, full
      set_overwrite(1'b1);
      send_request(OP_PUSH, 32'hA000_0004, 4'h0);        // drops the oldest
      send_request(OP_GET, 32'h0, 4'h1);
      send_request(OP_REMOVE, 32'h0, 4'h0);              // newest moves to the gap
      send_request(OP_POP, 32'h0, 4'h0);

      // capacity zero behaves as one slot
      apply_setting(5'd0, 1'b1, 1'b1);
      send_request(OP_PUSH, 32'hB000_0001, 4'h0);
      send_request(OP_PUSH, 32'hB000_0002, 4'h0);        // overwrite in a single slot
      send_request(OP_POP, 32'h0, 4'h0);

      // random phases across settings; phase four and the last two phases run without idling
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         apply_setting(cap_plan[phase], phase[0], phase[1]);
         idling_on   = (phase < RANDOM_PHASES - 2) && (phase != 4);
         push_weight = $urandom_range(25, 55);
         repeat (ITEMS_PER_PHASE) random_request(push_weight);
      end

      // wind down: all results in, then room for a full ordered remove
      idling_on = 1'b0;
      drain_requests();
      repeat (40) @(posedge clock);

      $display("covered %0d requests, %0d result words checked,",
               request_total, checked_count);
      $display("%0d register writes over %0d settings", csr_total, setting_total);
      if (fail_count == 0 && due_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // hang guard, far beyond the slowest correct run
   initial begin
      #5_000_000;
      $error("timeout with %0d result words outstanding", due_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
